### rtl/zbuffer_pixel_write_unit_defines.svh
// ----------------------------------------------------------------------------
// zbuffer_pixel_write_unit_defines.svh
// Assertion macros shared by the depth-buffered pixel store.
// ----------------------------------------------------------------------------
`ifndef ZBUFFER_PIXEL_WRITE_UNIT_DEFINES_SVH
`define ZBUFFER_PIXEL_WRITE_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define ZBPW_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define ZBPW_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/zbpw_pkg.sv
// ----------------------------------------------------------------------------
// zbpw_pkg
// Types, constants and colour packing for the depth-buffered pixel store.
// ----------------------------------------------------------------------------
package zbpw_pkg;

  // Store geometry.
  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int STORE_SIZE = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W     = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;

  // Field widths.
  localparam int COORD_W  = 12;
  localparam int LIM_W    = 13;
  localparam int LIN_W    = 25;
  localparam int DEPTH_W  = 24;
  localparam int CHAN_W   = 16;
  localparam int PIXEL_W  = 32;
  localparam int CFG_W    = 9;
  localparam int CFG_IDX_W = 1;
  localparam int ENTRY_W  = DEPTH_W + PIXEL_W;

  localparam logic [DEPTH_W-1:0] FAR_DEPTH  = 24'h7F_FFFF;
  localparam logic [CFG_W-1:0]   CFG_RESET  = 9'd256;
  localparam logic [12:0]        CHAN_FULL  = 13'd4096;

  // Operation codes.
  typedef enum logic [1:0] {
    OP_FRAGMENT = 2'd0,
    OP_CLEAR    = 2'd1,
    OP_READ     = 2'd2
  } op_t;

  // Result status codes.
  typedef enum logic [2:0] {
    STAT_WRITTEN    = 3'd0,
    STAT_DEPTH_FAIL = 3'd1,
    STAT_OUT_BOUNDS = 3'd2,
    STAT_CLEARED    = 3'd3,
    STAT_READ_DONE  = 3'd4
  } status_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACTIVE_WIDTH  = 1'b0,
    CFG_ACTIVE_HEIGHT = 1'b1
  } cfg_idx_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } state_t;

  // Clamp a Q3.12 channel to [0, 1.0], scale by 255 and keep the integer byte.
  function automatic logic [7:0] chan_byte(input logic [CHAN_W-1:0] c);
    logic [12:0] clamped;
    logic [20:0] scaled;
    if (c[CHAN_W-1]) begin
      clamped = '0;
    end else if (c[CHAN_W-2:0] > 15'(CHAN_FULL)) begin
      clamped = CHAN_FULL;
    end else begin
      clamped = c[12:0];
    end
    scaled = {clamped, 8'd0} - 21'(clamped);
    return scaled[19:12];
  endfunction

  // Pack three channels as ARGB with opaque alpha.
  function automatic logic [PIXEL_W-1:0] pack_colour(input logic [CHAN_W-1:0] r,
                                                     input logic [CHAN_W-1:0] g,
                                                     input logic [CHAN_W-1:0] b);
    return {8'hFF, chan_byte(r), chan_byte(g), chan_byte(b)};
  endfunction

endpackage

### rtl/zbpw_ram.sv
// ----------------------------------------------------------------------------
// zbpw_ram
// Single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module zbpw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                          wdata,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write on enable; read every cycle, returning the old contents on a write.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/zbuffer_pixel_write_unit.sv
// ----------------------------------------------------------------------------
// zbuffer_pixel_write_unit
// Depth-tested pixel store: fragment write, whole-buffer clear, pixel read.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken at a rising edge with start high and busy low. in_op
//   selects a fragment write, a clear or a read; the fragment fields are
//   coordinates, Q2.21 depth and Q3.12 colour.
//   Each request gives one result: out_valid is high for a single cycle with
//   out_status and out_pixel_value. The receiver cannot stall the block.
//   Fragment writes and reads: the request address goes to the store RAM at
//   the accepting edge, the next cycle compares and writes back, and the
//   result is shown in the cycle after that. A new request is taken only after
//   the lookup state, as the single RAM port serves both read and write-back.
//   Clear: one store entry per cycle until all STORE_SIZE (65536) entries are
//   written; the result is shown in the cycle after the last write, and busy
//   stays high throughout the writes.
//   Reset: registers return to 256 x 256 and a clearing pass writes the far
//   depth and a black pixel into every entry; busy is high during the pass
//   and no result is given for it. Configuration writes are taken at any
//   time.
// ----------------------------------------------------------------------------
`include "zbuffer_pixel_write_unit_defines.svh"

module zbuffer_pixel_write_unit (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [1:0]                            in_op,
  input  logic signed [zbpw_pkg::COORD_W-1:0]   in_x_coord,
  input  logic signed [zbpw_pkg::COORD_W-1:0]   in_y_coord,
  input  logic signed [zbpw_pkg::DEPTH_W-1:0]   in_depth,
  input  logic signed [zbpw_pkg::CHAN_W-1:0]    in_red,
  input  logic signed [zbpw_pkg::CHAN_W-1:0]    in_green,
  input  logic signed [zbpw_pkg::CHAN_W-1:0]    in_blue,
  output logic                                  out_valid,
  output logic [2:0]                            out_status,
  output logic [zbpw_pkg::PIXEL_W-1:0]          out_pixel_value,
  input  logic                                  cfg_we,
  input  logic [zbpw_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [zbpw_pkg::CFG_W-1:0]            cfg_data
);

  localparam int AW = zbpw_pkg::ADDR_W;
  localparam int LW = zbpw_pkg::LIM_W;
  localparam int NW = zbpw_pkg::LIN_W;
  localparam int EW = zbpw_pkg::ENTRY_W;
  localparam int PW = zbpw_pkg::PIXEL_W;
  localparam int DW = zbpw_pkg::DEPTH_W;

  zbpw_pkg::state_t state_r, state_nxt;

  logic [zbpw_pkg::CFG_W-1:0] active_width_r, active_height_r;

  logic [AW-1:0]  clr_addr_r;
  logic           clr_last;
  logic           clr_report_r;
  logic [PW-1:0]  clr_colour_r;

  logic [1:0]     req_op_r;
  logic           req_inside_r;
  logic [AW-1:0]  req_addr_r;
  logic [DW-1:0]  req_depth_r;
  logic [PW-1:0]  req_colour_r;

  logic           res_valid_r, res_valid_nxt;
  logic [2:0]     res_status_r, res_status_nxt;
  logic [PW-1:0]  res_pixel_r, res_pixel_nxt;

  logic           accept;
  logic [LW-1:0]  w_lim, h_lim, aw_ext, ah_ext;
  logic           acc_inside;
  logic [NW-1:0]  acc_lin;
  logic [AW-1:0]  acc_addr;
  logic [PW-1:0]  acc_colour;

  logic           ram_we;
  logic [AW-1:0]  ram_addr;
  logic [EW-1:0]  ram_wdata, ram_rdata;
  logic           depth_pass;

  assign accept   = start && (state_r == zbpw_pkg::ST_IDLE);
  assign clr_last = (clr_addr_r == AW'(zbpw_pkg::STORE_SIZE - 1));

  // Active area limited to the store size.
  assign aw_ext = LW'(active_width_r);
  assign ah_ext = LW'(active_height_r);
  assign w_lim  = (aw_ext > LW'(zbpw_pkg::MAX_WIDTH))  ? LW'(zbpw_pkg::MAX_WIDTH)  : aw_ext;
  assign h_lim  = (ah_ext > LW'(zbpw_pkg::MAX_HEIGHT)) ? LW'(zbpw_pkg::MAX_HEIGHT) : ah_ext;

  // Bounds check and linear address of the incoming request.
  assign acc_inside = !in_x_coord[zbpw_pkg::COORD_W-1] && !in_y_coord[zbpw_pkg::COORD_W-1] &&
                      (LW'(unsigned'(in_x_coord)) < w_lim) &&
                      (LW'(unsigned'(in_y_coord)) < h_lim);
  assign acc_lin    = NW'(unsigned'(in_y_coord)) * NW'(zbpw_pkg::MAX_WIDTH) +
                      NW'(unsigned'(in_x_coord));
  assign acc_addr   = acc_lin[AW-1:0];
  assign acc_colour = zbpw_pkg::pack_colour(in_red, in_green, in_blue);

  // Depth test against the entry read back from the store.
  assign depth_pass = $signed(req_depth_r) < $signed(ram_rdata[EW-1:PW]);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_width_r  <= zbpw_pkg::CFG_RESET;
      active_height_r <= zbpw_pkg::CFG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        zbpw_pkg::CFG_ACTIVE_WIDTH:  active_width_r  <= cfg_data;
        zbpw_pkg::CFG_ACTIVE_HEIGHT: active_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      zbpw_pkg::ST_CLEAR: begin
        if (clr_last) begin
          state_nxt = zbpw_pkg::ST_IDLE;
        end
      end
      zbpw_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = (in_op == zbpw_pkg::OP_CLEAR) ? zbpw_pkg::ST_CLEAR
                                                    : zbpw_pkg::ST_LOOKUP;
        end
      end
      zbpw_pkg::ST_LOOKUP: state_nxt = zbpw_pkg::ST_IDLE;
      default:             state_nxt = zbpw_pkg::ST_IDLE;
    endcase
  end

  // RAM control and result selection.
  always_comb begin
    busy           = 1'b1;
    ram_we         = 1'b0;
    ram_addr       = acc_addr;
    ram_wdata      = {req_depth_r, req_colour_r};
    res_valid_nxt  = 1'b0;
    res_status_nxt = zbpw_pkg::STAT_OUT_BOUNDS;
    res_pixel_nxt  = '0;
    unique case (state_r)
      zbpw_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_addr_r;
        ram_wdata = {zbpw_pkg::FAR_DEPTH, clr_colour_r};
        if (clr_last && clr_report_r) begin
          res_valid_nxt  = 1'b1;
          res_status_nxt = zbpw_pkg::STAT_CLEARED;
          res_pixel_nxt  = clr_colour_r;
        end
      end
      zbpw_pkg::ST_IDLE: begin
        busy = 1'b0;
      end
      zbpw_pkg::ST_LOOKUP: begin
        ram_addr      = req_addr_r;
        res_valid_nxt = 1'b1;
        if (req_inside_r) begin
          unique case (req_op_r)
            zbpw_pkg::OP_FRAGMENT: begin
              if (depth_pass) begin
                ram_we         = 1'b1;
                res_status_nxt = zbpw_pkg::STAT_WRITTEN;
                res_pixel_nxt  = req_colour_r;
              end else begin
                res_status_nxt = zbpw_pkg::STAT_DEPTH_FAIL;
              end
            end
            zbpw_pkg::OP_READ: begin
              res_status_nxt = zbpw_pkg::STAT_READ_DONE;
              res_pixel_nxt  = ram_rdata[PW-1:0];
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  end

  // State, clearing pass and result registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= zbpw_pkg::ST_CLEAR;
      clr_addr_r   <= '0;
      clr_report_r <= 1'b0;
      clr_colour_r <= '0;
      res_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      res_valid_r <= res_valid_nxt;
      if (state_r == zbpw_pkg::ST_CLEAR) begin
        clr_addr_r <= clr_addr_r + AW'(1);
      end
      if (accept && (in_op == zbpw_pkg::OP_CLEAR)) begin
        clr_addr_r   <= '0;
        clr_report_r <= 1'b1;
        clr_colour_r <= acc_colour;
      end
    end
  end

  // Request and result payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_op_r     <= in_op;
      req_inside_r <= acc_inside;
      req_addr_r   <= acc_addr;
      req_depth_r  <= in_depth;
      req_colour_r <= acc_colour;
    end
    res_status_r <= res_status_nxt;
    res_pixel_r  <= res_pixel_nxt;
  end

  // Combined depth and pixel store.
  zbpw_ram #(
    .WIDTH (EW),
    .DEPTH (zbpw_pkg::STORE_SIZE)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign out_valid       = res_valid_r;
  assign out_status      = res_status_r;
  assign out_pixel_value = res_pixel_r;

  // Checks.
  `ZBPW_ASSERT_NXT(a_no_back_to_back, out_valid, !out_valid, "results on consecutive cycles")
  `ZBPW_ASSERT_NXT(a_busy_after_accept, start && !busy, busy, "busy low after a request")
  `ZBPW_ASSERT_IMP(a_no_write_idle, ram_we, state_r != zbpw_pkg::ST_IDLE, "store write while idle")
  `ZBPW_ASSERT_NXT(a_lookup_result, state_r == zbpw_pkg::ST_LOOKUP, out_valid, "lookup gave no result")
  `ZBPW_ASSERT_IMP(a_written_opaque, out_valid && out_status == zbpw_pkg::STAT_WRITTEN,
                   out_pixel_value[31:24] == 8'hFF, "written pixel not opaque")

endmodule
